FILE: rtl/assert_macros.svh
// Assertion helpers, clocked on clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lr_pkg.sv
package lr_pkg;

  localparam int COORD_W = 6;
  localparam int ADDR_W  = 9;
  localparam int BIT_W   = 3;

  localparam int DISPLAY_WIDTH_DEF  = 64;
  localparam int DISPLAY_HEIGHT_DEF = 64;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
  } line_cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [ADDR_W-1:0]  byte_address;
    logic [BIT_W-1:0]   bit_index;
    logic               last_pixel;
  } pixel_t;

endpackage

FILE: rtl/line_rasterizer_core.sv
// Bresenham line rasterizer, one pixel beat per on-display step.
// A command passes through accept, setup (the spans, then two passes through the shared
// add/sub unit), one step per pixel, and a final flush.
// The first pixel leaves one on-display step after it is found; the last at the flush.
// Output stalls hold the stepping loop. in_ready is high only between commands.
// Reset (rst_n low at a rising edge) returns to idle and drops any pending pixel.
`include "assert_macros.svh"

module line_rasterizer_core #(
  parameter int DISPLAY_WIDTH  = lr_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = lr_pkg::DISPLAY_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lr_pkg::line_cmd_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lr_pkg::pixel_t    out_data
);

  localparam int CW  = lr_pkg::COORD_W;
  localparam int CW1 = lr_pkg::COORD_W + 1;
  localparam int EW  = lr_pkg::COORD_W + 2;
  localparam int AW  = lr_pkg::ADDR_W;
  localparam int BW  = lr_pkg::BIT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SPAN, S_DIFF, S_INIT, S_STEP, S_FLUSH
  } state_t;

  state_t                state_r;
  logic [CW-1:0]         xa_r, ya_r, xb_r, yb_r;
  logic [CW-1:0]         x_r, y_r;
  logic [CW-1:0]         major_r, minor_r;
  logic [CW-1:0]         cnt_r;
  logic                  x_dec_r, x_major_r;
  logic signed [EW-1:0]  err_r, inc_b_r;
  lr_pkg::pixel_t        pend_r, out_data_r;
  logic                  pend_valid_r, out_valid_r;

  // Endpoint swap so the line runs downwards
  logic                  swap;
  // Span calculation
  logic [CW-1:0]         dx, dy;
  logic                  x_dec, x_major;
  // Shared add/sub unit
  logic signed [EW-1:0]  add_a, add_b, add_sum;
  logic                  add_sub;
  logic signed [EW-1:0]  two_minor;
  // Current pixel
  logic                  on_disp, out_free, advance, err_neg;
  lr_pkg::pixel_t        cur_pix;
  // Output register load
  logic                  out_load;
  lr_pkg::pixel_t        pend_last;

  assign swap = in_data.start_y > in_data.end_y;

  assign x_dec   = xa_r >= xb_r;
  assign dx      = x_dec ? (xa_r - xb_r) : (xb_r - xa_r);
  assign dy      = yb_r - ya_r;
  assign x_major = x_dec ? (dx >= dy) : (dx > dy);

  assign two_minor = $signed({1'b0, minor_r, 1'b0});
  assign err_neg   = err_r[EW-1];

  always_comb begin
    add_a   = two_minor;
    add_b   = $signed({2'b00, major_r});
    add_sub = 1'b1;
    unique case (state_r)
      S_DIFF: begin
        add_b = $signed({1'b0, major_r, 1'b0});
      end
      S_STEP: begin
        add_a   = err_r;
        add_b   = err_neg ? two_minor : inc_b_r;
        add_sub = 1'b0;
      end
      default: begin
        add_b = $signed({2'b00, major_r});
      end
    endcase
    add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);
  end

  always_comb begin
    cur_pix.pixel_x      = x_r;
    cur_pix.pixel_y      = y_r;
    cur_pix.byte_address = AW'(x_r) + AW'(y_r[CW-1:BW]) * AW'(DISPLAY_WIDTH);
    cur_pix.bit_index    = y_r[BW-1:0];
    cur_pix.last_pixel   = 1'b0;
  end

  always_comb begin
    pend_last            = pend_r;
    pend_last.last_pixel = 1'b1;
  end

  assign on_disp  = ({1'b0, x_r} < CW1'(DISPLAY_WIDTH)) &&
                    ({1'b0, y_r} < CW1'(DISPLAY_HEIGHT));
  assign out_free = !out_valid_r || out_ready;
  // Hold the step while a found pixel cannot push the pending one out
  assign advance  = !(on_disp && pend_valid_r && !out_free);
  assign out_load = ((state_r == S_STEP) && advance && on_disp && pend_valid_r) ||
                    ((state_r == S_FLUSH) && pend_valid_r && out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            xa_r    <= swap ? in_data.end_x   : in_data.start_x;
            ya_r    <= swap ? in_data.end_y   : in_data.start_y;
            xb_r    <= swap ? in_data.start_x : in_data.end_x;
            yb_r    <= swap ? in_data.start_y : in_data.end_y;
            state_r <= S_SPAN;
          end
        end
        S_SPAN: begin
          x_dec_r   <= x_dec;
          x_major_r <= x_major;
          major_r   <= x_major ? dx : dy;
          minor_r   <= x_major ? dy : dx;
          cnt_r     <= x_major ? dx : dy;
          x_r       <= xa_r;
          y_r       <= ya_r;
          state_r   <= S_DIFF;
        end
        S_DIFF: begin
          inc_b_r <= add_sum;
          state_r <= S_INIT;
        end
        S_INIT: begin
          err_r   <= add_sum;
          state_r <= S_STEP;
        end
        S_STEP: begin
          if (advance) begin
            if (on_disp) begin
              pend_r       <= cur_pix;
              pend_valid_r <= 1'b1;
              if (pend_valid_r) begin
                out_data_r <= pend_r;
              end
            end
            err_r <= add_sum;
            if (x_major_r || !err_neg) begin
              x_r <= x_dec_r ? (x_r - CW'(1)) : (x_r + CW'(1));
            end
            if (!x_major_r || !err_neg) begin
              y_r <= y_r + CW'(1);
            end
            if (cnt_r == '0) begin
              state_r <= S_FLUSH;
            end else begin
              cnt_r <= cnt_r - CW'(1);
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid_r) begin
            state_r <= S_IDLE;
          end else if (out_free) begin
            out_data_r   <= pend_last;
            pend_valid_r <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_IMPL(a_idle_no_pend, state_r == S_IDLE, !pend_valid_r,
    "pending pixel left over between commands")
  `ASSERT_IMPL(a_pend_on_disp, pend_valid_r,
    ({1'b0, pend_r.pixel_x} < CW1'(DISPLAY_WIDTH)) &&
    ({1'b0, pend_r.pixel_y} < CW1'(DISPLAY_HEIGHT)),
    "pending pixel lies off the display")
  `ASSERT_IMPL(a_out_bit, out_valid_r,
    (out_data_r.bit_index == out_data_r.pixel_y[BW-1:0]) && !out_data_r.pixel_x[0] ==
    !out_data_r.byte_address[0],
    "output beat bit index or address out of step with its pixel")
  `ASSERT_CLK(a_step_stall,
    (state_r == S_STEP && !advance) |=> (state_r == S_STEP && $stable(cnt_r)),
    "stepping moved on while its pixel could not be taken")

endmodule
